// ===== src/wpt_pkg.sv =====
// Shared constants and the wheel step table for the wheel primality tester.
package wpt_pkg;

	// Default width of the tested number.
	localparam int NUMBER_BITS_DEF = 31;

	// Candidate sequencer: 2, 3, 5, then the mod-30 wheel 7, 11, ..., 31, 37, ...
	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] IDX_FIRST = 4'd0;  // candidate 2
	localparam logic [IDX_W-1:0] IDX_LAST  = 4'd10; // last offset of a wheel turn (31)
	localparam logic [IDX_W-1:0] IDX_LOOP  = 4'd3;  // first offset of a wheel turn (7)

	localparam int DELTA_W = 3;
	localparam int FIRST_CAND = 2;

	// Gap from the candidate at position idx to the next one.
	function automatic logic [DELTA_W-1:0] wheel_delta(input logic [IDX_W-1:0] idx);
		logic [DELTA_W-1:0] d;
		case (idx)
			4'd0:    d = 3'd1; // 2 -> 3
			4'd1:    d = 3'd2; // 3 -> 5
			4'd2:    d = 3'd2; // 5 -> 7
			4'd3:    d = 3'd4; // 7 -> 11
			4'd4:    d = 3'd2; // 11 -> 13
			4'd5:    d = 3'd4; // 13 -> 17
			4'd6:    d = 3'd2; // 17 -> 19
			4'd7:    d = 3'd4; // 19 -> 23
			4'd8:    d = 3'd6; // 23 -> 29
			4'd9:    d = 3'd2; // 29 -> 31
			4'd10:   d = 3'd6; // 31 -> 37, next turn
			default: d = 3'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== src/wheel_primality_test.sv =====
// Wheel primality tester: trial division by 2, 3, 5 and a mod-30 wheel, bit-serial divider.
//
// Channel   Direction  Handshake                    Payload
// --------  ---------  ---------------------------  ----------------------------
// command   in         start high while busy low    number [NUMBER_BITS-1:0]
// result    out        done high for one cycle      is_prime
//
// Run: numbers below 2 answer in the cycle after the transfer. Otherwise each
// tried candidate runs the restoring divider (one quotient bit per cycle)
// and then a check step. Candidates run 2, 3, 5, 7, 11, ... up to about
// sqrt(number), so a large prime at 31 bits takes about 12400 candidates.
// Reset: arst_n clears the sequencer and the strobe; no clearing pass.
// Stalls: the receiver cannot stall; busy is high from the transfer until the
// cycle in which done is raised, and a new command may be taken in that cycle.
module wheel_primality_test
	import wpt_pkg::*;
#(
	parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [NUMBER_BITS-1:0] number,
	output logic                   done,
	output logic                   is_prime
);

	localparam int CNT_W = $clog2(NUMBER_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUMBER_BITS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_CHECK
	} state_t;

	state_t                 state_q;
	logic                   done_q;
	logic                   is_prime_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       idx_q;
	logic [NUMBER_BITS-1:0] n_q;     // number under test, held for every candidate
	logic [NUMBER_BITS-1:0] cand_q;  // current trial divisor
	logic [NUMBER_BITS-1:0] dq_q;    // dividend bits shift out the top, quotient bits in
	logic [NUMBER_BITS-1:0] rem_q;   // partial remainder, always below cand_q

	// One restoring division step: bring down the next dividend bit, try to subtract.
	logic [NUMBER_BITS:0]   trial;
	logic [NUMBER_BITS+1:0] diff;
	logic                   q_bit;
	logic [NUMBER_BITS-1:0] rem_next;
	logic                   small_n;
	logic [NUMBER_BITS-1:0] cand_next;

	assign trial     = {rem_q, dq_q[NUMBER_BITS-1]};
	assign diff      = {1'b0, trial} - {2'b00, cand_q};
	assign q_bit     = ~diff[NUMBER_BITS+1];
	assign rem_next  = q_bit ? diff[NUMBER_BITS-1:0] : trial[NUMBER_BITS-1:0];
	assign small_n   = (number[NUMBER_BITS-1:1] == '0);
	assign cand_next = cand_q + NUMBER_BITS'(wheel_delta(idx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			done_q     <= 1'b0;
			is_prime_q <= 1'b0;
			cnt_q      <= '0;
			idx_q      <= IDX_FIRST;
			n_q        <= '0;
			cand_q     <= NUMBER_BITS'(FIRST_CAND);
			dq_q       <= '0;
			rem_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						n_q    <= number;
						dq_q   <= number;
						rem_q  <= '0;
						cand_q <= NUMBER_BITS'(FIRST_CAND);
						idx_q  <= IDX_FIRST;
						cnt_q  <= '0;
						if (small_n) begin
							// zero and one: not prime, answer at once
							done_q     <= 1'b1;
							is_prime_q <= 1'b0;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					dq_q  <= {dq_q[NUMBER_BITS-2:0], q_bit};
					rem_q <= rem_next;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// dq_q now holds number / cand, rem_q the remainder
					if (dq_q < cand_q) begin
						// cand squared exceeds number: no divisor left
						done_q     <= 1'b1;
						is_prime_q <= 1'b1;
						state_q    <= S_IDLE;
					end else if (rem_q == '0) begin
						done_q     <= 1'b1;
						is_prime_q <= 1'b0;
						state_q    <= S_IDLE;
					end else begin
						cand_q  <= cand_next;
						idx_q   <= (idx_q == IDX_LAST) ? IDX_LOOP : idx_q + 1'b1;
						dq_q    <= n_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign is_prime = is_prime_q;

	// A result only follows a transfer or the end of a test run.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result strobe without a preceding command or run");

	// The divider keeps its partial remainder below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> rem_q < cand_q)
		else $error("partial remainder not below candidate");

	// Trial divisors never drop below two while a test runs.
	a_cand_min: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> cand_q >= NUMBER_BITS'(FIRST_CAND))
		else $error("candidate below two");

	// A run ends only from the check cycle.
	a_end_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(state_q) == S_CHECK)
		else $error("run ended outside the check cycle");

endmodule
